FILE: design/bsrs_pkg.sv
// ----------------------------------------------------------------------------
// bsrs_pkg
// Shared types and constants for the bit stream run statistics block.
// ----------------------------------------------------------------------------
package bsrs_pkg;

    localparam int unsigned CW = 32;
    localparam int unsigned BIN_W = 7;
    localparam int unsigned WSZ_W = 7;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_READ = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic               bit_req;
        logic [BIN_W-1:0]   bin_index;
        logic               bin_kind;
    } t_cmd;

endpackage

FILE: design/bsrs_front.sv
// ----------------------------------------------------------------------------
// bsrs_front
// Input side: accept beats, unpack fields into commands, two-entry queue.
// ----------------------------------------------------------------------------
module bsrs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [15:0]     i_data,
    input  logic            i_user,
    output logic            o_cmd_valid,
    output bsrs_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_take
);
    import bsrs_pkg::*;

    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_in;

    assign w_in.mode      = t_mode'(i_user);
    assign w_in.bit_req   = i_data[0];
    assign w_in.bin_index = i_data[BIN_W:1];
    assign w_in.bin_kind  = i_data[BIN_W+1];

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
        if (w_push) begin
            r_q[r_rd ^ r_cnt[0]] <= w_in;
        end
    end
endmodule

FILE: design/bsrs_back.sv
// ----------------------------------------------------------------------------
// bsrs_back
// Execute side: counters, run tracking, window, histogram memories, output reg.
// ----------------------------------------------------------------------------
module bsrs_back #(
    parameter int unsigned HIST_BINS  = 100,
    parameter int unsigned MAX_WINDOW = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [6:0]              i_wsize,
    input  logic                    i_cmd_valid,
    input  bsrs_pkg::t_cmd          i_cmd,
    output logic                    o_cmd_take,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [383:0]            o_data
);
    import bsrs_pkg::*;

    localparam int unsigned HW  = $clog2(HIST_BINS);
    localparam int unsigned MWW = $clog2(MAX_WINDOW + 1);
    localparam logic [CW-1:0] CMAX = '1;

    // stage 1 registers
    logic          r_s1_v;
    t_cmd          r_s1_cmd;
    logic          r_s1_close;
    logic          r_s1_kind;
    logic [HW-1:0] r_s1_addr;
    logic          r_s1_hit;
    logic [CW-1:0] r_rd1, r_rd0;

    // architectural state
    logic          r_last, r_seen;
    logic [CW-1:0] r_run, r_items, r_ones;
    logic [CW-1:0] r_tr [4];
    logic [CW-1:0] r_max [2];
    logic [CW-1:0] r_tot [2];
    logic [CW-1:0] r_dense, r_full;
    logic [MAX_WINDOW-1:0] r_win;
    logic [HIST_BINS-1:0]  r_hv1, r_hv0;
    logic [CW-1:0] r_h1 [HIST_BINS];
    logic [CW-1:0] r_h0 [HIST_BINS];

    // last write for forwarding
    logic          r_fw_v, r_fw_k;
    logic [HW-1:0] r_fw_a;
    logic [CW-1:0] r_fw_d;

    logic          r_ov;
    logic [383:0]  r_od;

    logic          w_adv, w_go;
    logic          w_b, w_close, w_k;
    logic [HW-1:0] w_addr;
    logic          w_hit;
    logic [MWW-1:0] w_w;
    logic [MAX_WINDOW-1:0] w_win;
    logic [MAX_WINDOW-1:0] w_mask;
    logic [MWW-1:0] w_cnt;
    logic [CW-1:0] w_items;
    logic [CW-1:0] w_old, w_new;
    logic [CW-1:0] w_bv;

    function automatic logic [CW-1:0] sat(input logic [CW-1:0] v);
        return (v == CMAX) ? v : v + 1'b1;
    endfunction

    assign w_adv      = !r_ov || i_ready;
    assign o_cmd_take = w_adv;
    assign w_go       = i_cmd_valid && w_adv;
    assign o_valid    = r_ov;
    assign o_data     = r_od;

    assign w_b     = i_cmd.bit_req;
    assign w_close = (i_cmd.mode == MODE_PUSH) && r_seen && (w_b != r_last);
    assign w_k     = (i_cmd.mode == MODE_PUSH) ? ~r_last : i_cmd.bin_kind;
    assign w_hit   = (i_cmd.mode == MODE_PUSH)
                   ? (r_run < CW'(HIST_BINS))
                   : (32'(i_cmd.bin_index) < HIST_BINS);
    assign w_addr  = (i_cmd.mode == MODE_PUSH) ? r_run[HW-1:0]
                   : HW'(i_cmd.bin_index);

    always_comb begin
        if (i_wsize == 7'd0) begin
            w_w = MWW'(1);
        end else if (32'(i_wsize) > MAX_WINDOW) begin
            w_w = MWW'(MAX_WINDOW);
        end else begin
            w_w = MWW'(i_wsize);
        end
        w_win   = {r_win[MAX_WINDOW-2:0], w_b};
        w_mask  = ~({MAX_WINDOW{1'b1}} << w_w);
        w_cnt   = MWW'($countones(w_win & w_mask));
        w_items = sat(r_items);
    end

    always_comb begin
        if (r_fw_v && r_fw_k == r_s1_kind && r_fw_a == r_s1_addr) begin
            w_old = r_fw_d;
        end else if (r_s1_kind) begin
            w_old = r_rd0;
        end else begin
            w_old = r_rd1;
        end
        w_new = sat(w_old);
        w_bv  = (r_s1_cmd.mode == MODE_READ && r_s1_hit) ? w_old : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_ov    <= 1'b0;
            r_last  <= 1'b0;
            r_seen  <= 1'b0;
            r_run   <= CW'(1);
            r_items <= '0;
            r_ones  <= '0;
            r_tr    <= '{default: '0};
            r_max   <= '{default: '0};
            r_tot   <= '{default: '0};
            r_dense <= '0;
            r_full  <= '0;
            r_win   <= '0;
            r_hv1   <= '0;
            r_hv0   <= '0;
            r_fw_v  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1_v <= i_cmd_valid;
            end
            if (r_s1_v && w_adv) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (w_go && i_cmd.mode == MODE_PUSH) begin
                if (r_seen) begin
                    r_tr[{~r_last, ~w_b}] <= sat(r_tr[{~r_last, ~w_b}]);
                    if (w_b == r_last) begin
                        r_run <= sat(r_run);
                    end else begin
                        if (r_run > r_max[w_k]) begin
                            r_max[w_k] <= r_run;
                        end
                        r_tot[w_k] <= sat(r_tot[w_k]);
                        r_run <= CW'(1);
                    end
                end
                r_seen <= 1'b1;
                r_last <= w_b;
                if (w_b) begin
                    r_ones <= sat(r_ones);
                end
                r_win   <= w_win;
                r_items <= w_items;
                if (w_items >= CW'(w_w)) begin
                    r_full <= sat(r_full);
                    if ({w_cnt, 1'b0} > {1'b0, w_w}) begin
                        r_dense <= sat(r_dense);
                    end
                end
            end
            if (r_s1_v && w_adv) begin
                r_fw_v <= r_s1_close && r_s1_hit;
            end
            if (r_s1_v && w_adv && r_s1_close && r_s1_hit) begin
                if (r_s1_kind) begin
                    r_hv0[r_s1_addr] <= 1'b1;
                end else begin
                    r_hv1[r_s1_addr] <= 1'b1;
                end
            end
        end
        if (w_go) begin
            r_s1_cmd   <= i_cmd;
            r_s1_close <= w_close;
            r_s1_kind  <= w_k;
            r_s1_addr  <= w_addr;
            r_s1_hit   <= w_hit;
            r_rd1      <= r_hv1[w_addr] ? r_h1[w_addr] : '0;
            r_rd0      <= r_hv0[w_addr] ? r_h0[w_addr] : '0;
        end
        if (r_s1_v && w_adv) begin
            r_fw_k <= r_s1_kind;
            r_fw_a <= r_s1_addr;
            r_fw_d <= w_new;
            if (r_s1_close && r_s1_hit) begin
                if (r_s1_kind) begin
                    r_h0[r_s1_addr] <= w_new;
                end else begin
                    r_h1[r_s1_addr] <= w_new;
                end
            end
            r_od <= {w_bv, r_full, r_dense, r_tot[1], r_tot[0], r_max[1], r_max[0],
                     r_ones, r_tr[3], r_tr[2], r_tr[1], r_tr[0]};
        end
    end
endmodule

FILE: design/bit_stream_run_statistics_top.sv
// ----------------------------------------------------------------------------
// bit_stream_run_statistics_top
// Run, transition and window statistics over a bit stream.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle unless the output stalls; each yields one
// registered result beat. Counters update as a beat enters execute; the
// histogram read is a registered memory read with forwarding of the previous
// write, so a histogram update or read follows every beat without a stall.
module bit_stream_run_statistics_top #(
    parameter int unsigned HIST_BINS  = 100,
    parameter int unsigned MAX_WINDOW = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // bit_req, bin_index[7:1], bin_kind
    input  logic         s_axis_tuser,   // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [383:0] m_axis_tdata    // one_one..zero_zero, ones_total,
                                         // longest_one/zero, one/zero_run_total,
                                         // dense_windows, full_windows, bin_value
);
    import bsrs_pkg::*;

    logic [6:0] r_wsize;
    logic       w_cv, w_take;
    t_cmd       w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= 7'd10;
        end else if (i_cfg_we) begin
            r_wsize <= i_cfg_wdata;
        end
    end

    bsrs_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata), .i_user(s_axis_tuser),
        .o_cmd_valid(w_cv), .o_cmd(w_cmd), .i_cmd_take(w_take)
    );

    bsrs_back #(.HIST_BINS(HIST_BINS), .MAX_WINDOW(MAX_WINDOW)) u_back (
        .i_clk, .i_rst_n, .i_wsize(r_wsize),
        .i_cmd_valid(w_cv), .i_cmd(w_cmd), .o_cmd_take(w_take),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );
endmodule

FILE: tb/bit_stream_run_statistics_top_tb.sv
// ----------------------------------------------------------------------------
// bit_stream_run_statistics_top_tb
// Drives pushes and histogram reads into the bit statistics block, predicts
// every result beat with an in-bench model of the counters, histograms and
// density window, and compares each result field by field.
// ----------------------------------------------------------------------------
module bit_stream_run_statistics_top_tb;
    import bsrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NBINS = 100;
    localparam int unsigned MAXW  = 64;
    localparam logic [31:0] CMAX  = 32'hFFFF_FFFF;
    localparam int unsigned TT_11 = 0;
    localparam int unsigned TT_10 = 1;
    localparam int unsigned TT_01 = 2;
    localparam int unsigned TT_00 = 3;
    localparam int unsigned K_ONE  = 0;
    localparam int unsigned K_ZERO = 1;

    typedef struct packed {
        logic [31:0] bin_value;
        logic [31:0] full_windows;
        logic [31:0] dense_windows;
        logic [31:0] zero_run_total;
        logic [31:0] one_run_total;
        logic [31:0] longest_zero_run;
        logic [31:0] longest_one_run;
        logic [31:0] ones_total;
        logic [31:0] zero_zero_count;
        logic [31:0] zero_one_count;
        logic [31:0] one_zero_count;
        logic [31:0] one_one_count;
    } t_stats;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [6:0]   i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;   // bit_req, bin_index, bin_kind
    logic         s_axis_tuser;   // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [383:0] m_axis_tdata;   // one_one_count .. bin_value

    bit_stream_run_statistics_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    logic [6:0]  win_cfg;
    logic        prev_bit;
    logic        started;
    logic [31:0] run_len;
    logic [31:0] pushed;
    logic [31:0] trans [4];
    logic [31:0] ones_cnt;
    logic [31:0] run_max [2];
    logic [31:0] run_cnt [2];
    logic [31:0] hist [2][NBINS];
    logic [MAXW-1:0] recent;   // bit 0 is the newest
    logic [31:0] dense_cnt;
    logic [31:0] full_cnt;

    t_stats stats_q[$];
    int     n_errors;
    int     n_results;
    int     n_pushes;
    int     n_reads;
    bit     quiet_out;
    bit     quiet_in;
    int     hold_cycles;

    function automatic logic [31:0] sat1(logic [31:0] v);
        return (v == CMAX) ? v : v + 32'd1;
    endfunction

    task automatic stats_reset();
        win_cfg   = 7'd10;
        prev_bit  = 1'b0;
        started   = 1'b0;
        run_len   = 32'd1;
        pushed    = '0;
        foreach (trans[i]) trans[i] = '0;
        ones_cnt  = '0;
        foreach (run_max[i]) run_max[i] = '0;
        foreach (run_cnt[i]) run_cnt[i] = '0;
        foreach (hist[k, b]) hist[k][b] = '0;
        recent    = '0;
        dense_cnt = '0;
        full_cnt  = '0;
    endtask

    function automatic t_stats stats_step(t_cmd c);
        t_stats r;
        int     w;
        int     ones_in_win;
        int     k;
        int     tt;
        if (c.mode == MODE_PUSH) begin
            if (started) begin
                tt = prev_bit ? (c.bit_req ? TT_11 : TT_10) : (c.bit_req ? TT_01 : TT_00);
                trans[tt] = sat1(trans[tt]);
                if (c.bit_req == prev_bit) begin
                    run_len = sat1(run_len);
                end else begin
                    k = prev_bit ? K_ONE : K_ZERO;
                    if (run_len < NBINS) hist[k][run_len] = sat1(hist[k][run_len]);
                    if (run_len > run_max[k]) run_max[k] = run_len;
                    run_cnt[k] = sat1(run_cnt[k]);
                    run_len = 32'd1;
                end
            end else begin
                started = 1'b1;
                run_len = 32'd1;
            end
            prev_bit = c.bit_req;
            if (c.bit_req) ones_cnt = sat1(ones_cnt);
            recent = {recent[MAXW-2:0], c.bit_req};
            pushed = sat1(pushed);
            w = (win_cfg == 0) ? 1 : (win_cfg > MAXW) ? MAXW : int'(win_cfg);
            ones_in_win = 0;
            for (int i = 0; i < w; i++) ones_in_win += recent[i];
            if (pushed >= w) begin
                full_cnt = sat1(full_cnt);
                if (ones_in_win * 2 > w) dense_cnt = sat1(dense_cnt);
            end
        end
        r.one_one_count    = trans[TT_11];
        r.one_zero_count   = trans[TT_10];
        r.zero_one_count   = trans[TT_01];
        r.zero_zero_count  = trans[TT_00];
        r.ones_total       = ones_cnt;
        r.longest_one_run  = run_max[K_ONE];
        r.longest_zero_run = run_max[K_ZERO];
        r.one_run_total    = run_cnt[K_ONE];
        r.zero_run_total   = run_cnt[K_ZERO];
        r.dense_windows    = dense_cnt;
        r.full_windows     = full_cnt;
        r.bin_value        = '0;
        if (c.mode == MODE_READ && c.bin_index < NBINS)
            r.bin_value = hist[c.bin_kind ? K_ZERO : K_ONE][c.bin_index];
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("bit_stream_run_statistics_top_tb: FAIL");
        $finish;
    end

    // output side: random backpressure plus an optional long hold
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 19);
            end
        end
    end

    always @(posedge i_clk) begin
        t_stats got;
        t_stats exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_stats'(m_axis_tdata);
            n_results++;
            if (stats_q.size() == 0) begin
                $error("result beat with no expectation waiting");
                n_errors++;
            end else begin
                exp_r = stats_q.pop_front();
                if (got.one_one_count !== exp_r.one_one_count) begin
                    $error("one_one_count exp %0d got %0d", exp_r.one_one_count, got.one_one_count);
                    n_errors++;
                end
                if (got.one_zero_count !== exp_r.one_zero_count) begin
                    $error("one_zero_count exp %0d got %0d", exp_r.one_zero_count, got.one_zero_count);
                    n_errors++;
                end
                if (got.zero_one_count !== exp_r.zero_one_count) begin
                    $error("zero_one_count exp %0d got %0d", exp_r.zero_one_count, got.zero_one_count);
                    n_errors++;
                end
                if (got.zero_zero_count !== exp_r.zero_zero_count) begin
                    $error("zero_zero_count exp %0d got %0d", exp_r.zero_zero_count,
                           got.zero_zero_count);
                    n_errors++;
                end
                if (got.ones_total !== exp_r.ones_total) begin
                    $error("ones_total exp %0d got %0d", exp_r.ones_total, got.ones_total);
                    n_errors++;
                end
                if (got.longest_one_run !== exp_r.longest_one_run) begin
                    $error("longest_one_run exp %0d got %0d", exp_r.longest_one_run,
                           got.longest_one_run);
                    n_errors++;
                end
                if (got.longest_zero_run !== exp_r.longest_zero_run) begin
                    $error("longest_zero_run exp %0d got %0d", exp_r.longest_zero_run,
                           got.longest_zero_run);
                    n_errors++;
                end
                if (got.one_run_total !== exp_r.one_run_total) begin
                    $error("one_run_total exp %0d got %0d", exp_r.one_run_total, got.one_run_total);
                    n_errors++;
                end
                if (got.zero_run_total !== exp_r.zero_run_total) begin
                    $error("zero_run_total exp %0d got %0d", exp_r.zero_run_total,
                           got.zero_run_total);
                    n_errors++;
                end
                if (got.dense_windows !== exp_r.dense_windows) begin
                    $error("dense_windows exp %0d got %0d", exp_r.dense_windows, got.dense_windows);
                    n_errors++;
                end
                if (got.full_windows !== exp_r.full_windows) begin
                    $error("full_windows exp %0d got %0d", exp_r.full_windows, got.full_windows);
                    n_errors++;
                end
                if (got.bin_value !== exp_r.bin_value) begin
                    $error("bin_value exp %0d got %0d", exp_r.bin_value, got.bin_value);
                    n_errors++;
                end
            end
        end
    end

    // tvalid stays up after an accepted beat; callers that stop sending drain()
    task automatic send_beat(t_cmd c);
        if (!quiet_in) begin
            while ($urandom_range(99) < 19) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.mode;
        s_axis_tdata  <= {7'd0, c.bin_kind, c.bin_index, c.bit_req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        stats_q.push_back(stats_step(c));
        if (c.mode == MODE_PUSH) n_pushes++;
        else n_reads++;
    endtask

    task automatic push_bit(logic b);
        t_cmd c;
        c.mode      = MODE_PUSH;
        c.bit_req   = b;
        c.bin_index = 7'($urandom_range(127));
        c.bin_kind  = 1'($urandom_range(1));
        send_beat(c);
    endtask

    task automatic read_bin(logic [6:0] idx, logic kind);
        t_cmd c;
        c.mode      = MODE_READ;
        c.bit_req   = 1'($urandom_range(1));
        c.bin_index = idx;
        c.bin_kind  = kind;
        send_beat(c);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (stats_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_window(logic [6:0] w);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        win_cfg = w;
    endtask

    task automatic test_directed();
        push_bit(1'b1);
        push_bit(1'b1);
        push_bit(1'b0);
        push_bit(1'b0);
        push_bit(1'b0);
        push_bit(1'b1);
        push_bit(1'b0);
        read_bin(7'd0, 1'b0);
        read_bin(7'd2, 1'b0);
        read_bin(7'd3, 1'b1);
        read_bin(7'd1, 1'b0);
        read_bin(7'd99, 1'b1);
        read_bin(7'd100, 1'b0);
        read_bin(7'd127, 1'b1);
        for (int i = 0; i < 8; i++) push_bit(1'b1);
        push_bit(1'b0);
        read_bin(7'd9, 1'b0);
    endtask

    task automatic test_window_sizes();
        logic [6:0] sizes [6] = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd33, 7'd10};
        foreach (sizes[s]) begin
            set_window(sizes[s]);
            for (int i = 0; i < 40; i++) push_bit(1'($urandom_range(99) < 60));
            read_bin(7'($urandom_range(8)), 1'($urandom_range(1)));
        end
    endtask

    // runs of random length with occasional long runs past the histogram range
    task automatic test_random_runs(int n_items);
        int sent;
        int len;
        logic b;
        sent = 0;
        b = 1'($urandom_range(1));
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                read_bin(7'($urandom_range(127)), 1'($urandom_range(1)));
                sent++;
            end else begin
                len = ($urandom_range(19) == 0) ? $urandom_range(101, 110) : $urandom_range(1, 8);
                for (int i = 0; i < len; i++) push_bit(b);
                sent += len;
                b = ~b;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 60;
        quiet_in = 1'b1;
        for (int i = 0; i < 30; i++) push_bit(1'($urandom_range(1)));
        quiet_in = 1'b0;
        drain();
        for (int i = 0; i < 8; i++) read_bin(7'(i), 1'($urandom_range(1)));
    endtask

    task automatic test_no_idle();
        quiet_in  = 1'b1;
        quiet_out = 1'b1;
        test_random_runs(100);
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
    endtask

    initial begin
        n_errors = 0; n_results = 0; n_pushes = 0; n_reads = 0;
        quiet_out = 1'b0; quiet_in = 1'b0; hold_cycles = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        stats_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_window_sizes();
        test_backpressure();
        test_no_idle();
        set_window(7'($urandom_range(1, 20)));
        test_random_runs(300);
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d pushes and %0d bin reads, %0d results checked",
                 n_pushes, n_reads, n_results);
        $display("window sizes 0, 1, 10, 33, 64, 127 plus random, long receiver hold");
        if (n_errors == 0 && stats_q.size() == 0) begin
            $display("bit_stream_run_statistics_top_tb: PASS");
        end else begin
            $display("bit_stream_run_statistics_top_tb: FAIL");
        end
        $finish;
    end
endmodule

FILE: bit_stream_run_statistics_top.f
design/bsrs_pkg.sv
design/bsrs_front.sv
design/bsrs_back.sv
design/bit_stream_run_statistics_top.sv
tb/bit_stream_run_statistics_top_tb.sv
